[rtl/wbvs_pkg.sv]
// ----------------------------------------------------------------------------
// wbvs_pkg
// Shared widths, codes, control structs and helpers for the windowed band
// volume sum block.
// ----------------------------------------------------------------------------
package wbvs_pkg;

  localparam int PRICE_W    = 32;
  localparam int VOL_W      = 32;
  localparam int WIDX_W     = 5;
  localparam int WEIGHT_W   = 16;
  localparam int UFRAC_W    = 16;
  localparam int LFRAC_W    = 17;
  localparam int WLEN_W     = 6;
  localparam int SUM_W      = 38;
  localparam int DELTA_W    = 39;
  localparam int PROD_W     = VOL_W + WEIGHT_W;
  localparam int BAND_W     = PRICE_W + LFRAC_W;
  localparam int ACC_EXT_W  = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int CNT9_W     = 9;

  // 1.0 in Q1.16
  localparam logic [LFRAC_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [0:0] {
    OP_FRAME  = 1'b0,
    OP_WEIGHT = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 2'd0,
    CFG_UPPER_FRACTION = 2'd1,
    CFG_LOWER_FRACTION = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   total;
    logic [VOL_W-1:0]   sell;
    logic [VOL_W-1:0]   buy;
  } frame_t;

  typedef struct packed {
    logic store_frame;
    logic write_weight;
    logic init_scan;
    logic band_hi;
    logic issue;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic window_ready;
    logic len_zero;
    logic scan_last;
    logic pipe_busy;
  } status_t;

  // drop the 16 fraction bits, clamp to the output range
  function automatic logic [SUM_W-1:0] sat_sum(input logic [ACC_EXT_W-1:0] acc);
    logic [ACC_EXT_W-17:0] s;
    s = acc[ACC_EXT_W-1:16];
    if (|s[ACC_EXT_W-17:SUM_W]) begin
      return '1;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

[rtl/wbvs_if.sv]
// ----------------------------------------------------------------------------
// wbvs_in_if / wbvs_out_if
// Valid/ready channels for frame and weight items in, sums out.
// ----------------------------------------------------------------------------
interface wbvs_in_if import wbvs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [0:0]          operation;
  logic [PRICE_W-1:0]  avg_price;
  logic [VOL_W-1:0]    total_volume;
  logic [VOL_W-1:0]    sell_volume;
  logic [VOL_W-1:0]    buy_volume;
  logic [WIDX_W-1:0]   weight_index;
  logic [WEIGHT_W-1:0] weight_value;

  modport source (
    output valid, operation, avg_price, total_volume, sell_volume, buy_volume,
           weight_index, weight_value,
    input  ready
  );
  modport sink (
    input  valid, operation, avg_price, total_volume, sell_volume, buy_volume,
           weight_index, weight_value,
    output ready
  );
endinterface

interface wbvs_out_if import wbvs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SUM_W-1:0]          total_sum;
  logic [SUM_W-1:0]          sell_sum;
  logic [SUM_W-1:0]          buy_sum;
  logic signed [DELTA_W-1:0] delta_sum;

  modport source (
    output valid, total_sum, sell_sum, buy_sum, delta_sum,
    input  ready
  );
  modport sink (
    input  valid, total_sum, sell_sum, buy_sum, delta_sum,
    output ready
  );
endinterface

[rtl/wbvs_datapath.sv]
// ----------------------------------------------------------------------------
// wbvs_datapath
// Frame ring, weight table, band bounds, three multiply-accumulate lanes and
// the result register.
// ----------------------------------------------------------------------------
module wbvs_datapath import wbvs_pkg::*; #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic [WLEN_W-1:0]         window_length_i,
  input  logic [UFRAC_W-1:0]        upper_fraction_i,
  input  logic [LFRAC_W-1:0]        lower_fraction_i,
  input  logic [PRICE_W-1:0]        avg_price_i,
  input  logic [VOL_W-1:0]          total_volume_i,
  input  logic [VOL_W-1:0]          sell_volume_i,
  input  logic [VOL_W-1:0]          buy_volume_i,
  input  logic [WIDX_W-1:0]         weight_index_i,
  input  logic [WEIGHT_W-1:0]       weight_value_i,
  output logic [SUM_W-1:0]          total_sum_o,
  output logic [SUM_W-1:0]          sell_sum_o,
  output logic [SUM_W-1:0]          buy_sum_o,
  output logic signed [DELTA_W-1:0] delta_sum_o
);

  localparam int SW    = $clog2(WINDOW_MAX);
  localparam int FW    = $clog2(WINDOW_MAX + 1);
  localparam int ACC_W = PROD_W + SW;
  localparam logic [SW-1:0]     LAST_SLOT = SW'(WINDOW_MAX - 1);
  localparam logic [SW:0]       WM_EXT    = (SW + 1)'(WINDOW_MAX);
  localparam logic [CNT9_W-1:0] WM_9      = CNT9_W'(WINDOW_MAX);

  frame_t              frame_mem  [WINDOW_MAX];
  logic [WEIGHT_W-1:0] weight_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] weight_vld_q;

  logic [SW-1:0] wr_slot_q, rd_ptr_q, pos_q;
  logic [FW-1:0] frames_q, remain_q;

  logic [PRICE_W-1:0] cur_price_q;
  logic [BAND_W-1:0]  lo_q, hi_q;
  logic               lo_open_q;

  frame_t              rd_frame_q;
  logic [WEIGHT_W-1:0] rd_weight_q;
  logic                rd_wvld_q;
  logic                v0_q, v1_q;

  logic [PROD_W-1:0] prod_tot_q, prod_sell_q, prod_buy_q;
  logic [ACC_W-1:0]  acc_tot_q, acc_sell_q, acc_buy_q;

  logic [SUM_W-1:0]          total_q, sell_q, buy_q;
  logic signed [DELTA_W-1:0] delta_q;

  // window length clipped to the ring size
  logic [CNT9_W-1:0] wl_9, len_9;
  logic [FW-1:0]     len;
  logic [SW:0]       start_sum, start_ptr;
  logic [CNT9_W-1:0] widx_9;
  logic              widx_ok;
  logic [SW-1:0]     widx;
  frame_t            frame_in;
  logic [LFRAC_W-1:0] band_factor;
  logic [BAND_W-1:0]  band_prod;
  logic [BAND_W-1:0]  p_ext;
  logic               in_band;
  logic [WEIGHT_W-1:0] w_eff;
  logic [SUM_W-1:0]   sat_tot, sat_sell, sat_buy;

  always_comb begin
    wl_9      = CNT9_W'(window_length_i);
    len_9     = (wl_9 > WM_9) ? WM_9 : wl_9;
    len       = len_9[FW-1:0];
    start_sum = {1'b0, wr_slot_q} + WM_EXT - (SW + 1)'(len);
    start_ptr = (start_sum >= WM_EXT) ? start_sum - WM_EXT : start_sum;
    widx_9    = CNT9_W'(weight_index_i);
    widx_ok   = widx_9 < WM_9;
    widx      = widx_9[SW-1:0];
    frame_in  = '{price: avg_price_i, total: total_volume_i,
                  sell: sell_volume_i, buy: buy_volume_i};
  end

  assign status_o.window_ready = CNT9_W'(frames_q) >= len_9;
  assign status_o.len_zero     = (len_9 == '0);
  assign status_o.scan_last    = (remain_q == FW'(1));
  assign status_o.pipe_busy    = v0_q | v1_q;

  // ring and weight table: one write, one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_frame) begin
      frame_mem[wr_slot_q] <= frame_in;
    end
    if (cmd_i.issue) begin
      rd_frame_q <= frame_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_weight && widx_ok) begin
      weight_mem[widx] <= weight_value_i;
    end
    if (cmd_i.issue) begin
      rd_weight_q <= weight_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_vld_q <= '0;
      wr_slot_q    <= '0;
      frames_q     <= '0;
      rd_ptr_q     <= '0;
      pos_q        <= '0;
      remain_q     <= '0;
      rd_wvld_q    <= 1'b0;
      v0_q         <= 1'b0;
      v1_q         <= 1'b0;
    end else begin
      if (cmd_i.write_weight && widx_ok) begin
        weight_vld_q[widx] <= 1'b1;
      end
      if (cmd_i.store_frame) begin
        wr_slot_q <= (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + 1'b1;
        if (frames_q != FW'(WINDOW_MAX)) begin
          frames_q <= frames_q + 1'b1;
        end
      end
      if (cmd_i.init_scan) begin
        rd_ptr_q <= start_ptr[SW-1:0];
        pos_q    <= '0;
        remain_q <= len;
      end else if (cmd_i.issue) begin
        rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
        pos_q    <= pos_q + 1'b1;
        remain_q <= remain_q - 1'b1;
      end
      if (cmd_i.issue) begin
        rd_wvld_q <= weight_vld_q[pos_q];
      end
      v0_q <= cmd_i.issue;
      v1_q <= v0_q;
    end
  end

  // band bounds, one shared multiplier: lower bound on init_scan, upper on band_hi
  always_comb begin
    band_factor = cmd_i.band_hi ? ONE_Q16 + LFRAC_W'(upper_fraction_i)
                                : ONE_Q16 - lower_fraction_i;
    band_prod   = cur_price_q * band_factor;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_frame) begin
      cur_price_q <= avg_price_i;
    end
    if (cmd_i.init_scan) begin
      lo_q      <= band_prod;
      lo_open_q <= lower_fraction_i > ONE_Q16;  // lower bound below zero
    end
    if (cmd_i.band_hi) begin
      hi_q <= band_prod;
    end
  end

  // stage 1: band test and products
  always_comb begin
    p_ext   = {1'b0, rd_frame_q.price, 16'b0};
    in_band = (lo_open_q || (p_ext > lo_q)) && (p_ext < hi_q);
    w_eff   = (in_band && rd_wvld_q) ? rd_weight_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (v0_q) begin
      prod_tot_q  <= rd_frame_q.total * w_eff;
      prod_sell_q <= rd_frame_q.sell * w_eff;
      prod_buy_q  <= rd_frame_q.buy * w_eff;
    end
  end

  // stage 2: accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_scan) begin
      acc_tot_q  <= '0;
      acc_sell_q <= '0;
      acc_buy_q  <= '0;
    end else if (v1_q) begin
      acc_tot_q  <= acc_tot_q + ACC_W'(prod_tot_q);
      acc_sell_q <= acc_sell_q + ACC_W'(prod_sell_q);
      acc_buy_q  <= acc_buy_q + ACC_W'(prod_buy_q);
    end
  end

  always_comb begin
    sat_tot  = sat_sum(ACC_EXT_W'(acc_tot_q));
    sat_sell = sat_sum(ACC_EXT_W'(acc_sell_q));
    sat_buy  = sat_sum(ACC_EXT_W'(acc_buy_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      total_q <= sat_tot;
      sell_q  <= sat_sell;
      buy_q   <= sat_buy;
      delta_q <= $signed({1'b0, sat_buy} - {1'b0, sat_sell});
    end
  end

  assign total_sum_o = total_q;
  assign sell_sum_o  = sell_q;
  assign buy_sum_o   = buy_q;
  assign delta_sum_o = delta_q;

endmodule

[rtl/wbvs_ctrl.sv]
// ----------------------------------------------------------------------------
// wbvs_ctrl
// Sequencer: takes items, runs band setup, window scan and drain, and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module wbvs_ctrl import wbvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [0:0] in_op_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BAND_HI,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_WEIGHT) begin
            cmd_o.write_weight = 1'b1;
          end else begin
            cmd_o.store_frame = 1'b1;
          end
        end
      end
      ST_CHECK:   cmd_o.init_scan = status_i.window_ready;
      ST_BAND_HI: cmd_o.band_hi = 1'b1;
      ST_SCAN:    cmd_o.issue = 1'b1;
      ST_DONE:    cmd_o.load_result = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.store_frame) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK:   state_q <= status_i.window_ready ? ST_BAND_HI : ST_IDLE;
        ST_BAND_HI: state_q <= status_i.len_zero ? ST_DRAIN : ST_SCAN;
        ST_SCAN: begin
          if (status_i.scan_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd_o.load_result) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid rose outside the done state");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("pending result dropped");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && status_i.scan_last |=> state_q == ST_DRAIN)
    else $error("scan did not end after the last entry");
`endif

endmodule

[rtl/windowed_band_volume_sum.sv]
// ----------------------------------------------------------------------------
// windowed_band_volume_sum
// Weighted in-band volume sums over the newest frames of a ring.
// ----------------------------------------------------------------------------
// A weight beat is written to the table and the input stays ready. A frame
// beat that leaves the window short is stored and checked, then the input
// is ready again. One that yields a result runs the whole scan before the
// next beat is taken. The scan reads one ring entry per cycle into three
// multiply-accumulate lanes; a check step and a band setup step come before
// it, and a drain and a result load after it. A finished result waits in the
// output register while the next beat is taken. The load waits, and so does
// the input, while the previous result has not been taken. No clearing pass
// is needed after reset.
module windowed_band_volume_sum import wbvs_pkg::*; #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wbvs_in_if.sink               frame_i,
  wbvs_out_if.source            result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [WLEN_W-1:0]  window_length_q;
  logic [UFRAC_W-1:0] upper_fraction_q;
  logic [LFRAC_W-1:0] lower_fraction_q;

  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q  <= 6'd32;
      upper_fraction_q <= '0;
      lower_fraction_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_LENGTH:  window_length_q  <= cfg_wdata_i[WLEN_W-1:0];
        CFG_UPPER_FRACTION: upper_fraction_q <= cfg_wdata_i[UFRAC_W-1:0];
        CFG_LOWER_FRACTION: lower_fraction_q <= cfg_wdata_i[LFRAC_W-1:0];
        default: ;
      endcase
    end
  end

  wbvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_op_i     (frame_i.operation),
    .in_ready_o  (frame_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wbvs_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .window_length_i  (window_length_q),
    .upper_fraction_i (upper_fraction_q),
    .lower_fraction_i (lower_fraction_q),
    .avg_price_i      (frame_i.avg_price),
    .total_volume_i   (frame_i.total_volume),
    .sell_volume_i    (frame_i.sell_volume),
    .buy_volume_i     (frame_i.buy_volume),
    .weight_index_i   (frame_i.weight_index),
    .weight_value_i   (frame_i.weight_value),
    .total_sum_o      (result_o.total_sum),
    .sell_sum_o       (result_o.sell_sum),
    .buy_sum_o        (result_o.buy_sum),
    .delta_sum_o      (result_o.delta_sum)
  );

endmodule
